// ===== rtl/ptd_pkg.sv =====
// Package for the trial-division primality tester.
// Holds widths, wheel constants and the sequencer types; no dependencies.
`default_nettype none

package ptd_pkg;

	localparam int CAND_BITS      = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int DIV_TWO     = 2;
	localparam int DIV_THREE   = 3;
	localparam int SMALL_FIVE  = 5;
	localparam int WHEEL_FIRST = 5;
	localparam int WHEEL_STEP  = 6;
	localparam int PAIR_GAP    = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_FIN
	} ptd_state_t;

	typedef enum logic [1:0] {
		TEST_MOD2,
		TEST_MOD3,
		TEST_LO,
		TEST_HI
	} ptd_test_t;

endpackage

`default_nettype wire

// ===== rtl/ptd_if.sv =====
// Valid/ready channels of the primality tester: candidate in, flag out.
// Depends on ptd_pkg for the candidate width.
`default_nettype none

interface ptd_cand_if
	import ptd_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CAND_BITS-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink (input valid, input candidate, output ready);
endinterface

interface ptd_result_if;
	logic valid;
	logic ready;
	logic is_prime;

	modport source (output valid, output is_prime, input ready);
	modport sink (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

// ===== rtl/primality_trial_division.sv =====
// Top level of the trial-division primality tester (6k +/- 1 wheel).
// Depends on ptd_pkg, ptd_if and ptd_serial_div.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------
//   cand     | in  | valid / ready | candidate [31:0]
//   result   | out | valid / ready | is_prime
//
// Each trial divisor is worked on the one bit-serial divider; 0..3 and 5 are
// settled in the idle state without it, and every other candidate is divided
// by 2, by 3 and then by the wheel pairs until a verdict is reached.
// One item is worked at a time; cand is ready whenever the sequencer is idle,
// also while a finished flag waits in the output register.
// Reset clears the sequencer and the output valid; no clearing pass.
`default_nettype none

module primality_trial_division
	import ptd_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ptd_cand_if.sink      cand,
	ptd_result_if.source  result
);

	ptd_state_t state_q, state_d;
	ptd_test_t  test_q, test_d;

	logic [CAND_BITS+VALUE_BITS-1:0] cand_ext;
	logic [VALUE_BITS-1:0]           n_in;
	logic [VALUE_BITS-1:0]           n_q;
	logic [VALUE_BITS-1:0]           d_q, d_d;
	logic                            res_q, res_d;
	logic                            out_valid_q;
	logic                            out_flag_q;
	logic                            out_load;
	logic                            accept;

	logic                  div_start;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_den;
	logic [VALUE_BITS-1:0] div_quot;
	logic [VALUE_BITS-1:0] div_rem;
	logic                  rem_zero;

	assign cand_ext = {{VALUE_BITS{1'b0}}, cand.candidate};
	assign n_in     = cand_ext[VALUE_BITS-1:0];
	assign accept   = cand.valid && cand.ready;
	assign rem_zero = (div_rem == '0);

	ptd_serial_div #(
		.VALUE_BITS (VALUE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (div_den),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_comb begin
		case (test_q)
			TEST_MOD2: div_den = VALUE_BITS'(DIV_TWO);
			TEST_MOD3: div_den = VALUE_BITS'(DIV_THREE);
			TEST_LO:   div_den = d_q;
			default:   div_den = d_q + VALUE_BITS'(PAIR_GAP);
		endcase
	end

	always_comb begin
		state_d    = state_q;
		test_d     = test_q;
		d_d        = d_q;
		res_d      = res_q;
		div_start  = 1'b0;
		cand.ready = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cand.ready = 1'b1;
				if (cand.valid) begin
					if (n_in <= VALUE_BITS'(1)) begin
						res_d   = 1'b0;
						state_d = ST_FIN;
					end else if (n_in <= VALUE_BITS'(DIV_THREE) ||
							n_in == VALUE_BITS'(SMALL_FIVE)) begin
						res_d   = 1'b1;
						state_d = ST_FIN;
					end else begin
						test_d  = TEST_MOD2;
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done) begin
					state_d = ST_START;
					unique case (test_q)
						TEST_MOD2: begin
							test_d = TEST_MOD3;
						end
						TEST_MOD3: begin
							test_d = TEST_LO;
							d_d    = VALUE_BITS'(WHEEL_FIRST);
						end
						TEST_LO: begin
							test_d = TEST_HI;
						end
						TEST_HI: begin
							test_d = TEST_LO;
							d_d    = d_q + VALUE_BITS'(WHEEL_STEP);
						end
					endcase
					if (test_q == TEST_LO && div_quot < d_q) begin
						res_d   = 1'b1;
						state_d = ST_FIN;
					end else if (rem_zero) begin
						res_d   = 1'b0;
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			test_q      <= TEST_MOD2;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			test_q  <= test_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= n_in;
		end
		d_q   <= d_d;
		res_q <= res_d;
		if (out_load) begin
			out_flag_q <= res_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.is_prime = out_flag_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_WAIT)
		else $error("divider finished outside the wait state");

	a_wheel_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && (test_q == TEST_LO || test_q == TEST_HI))
			|-> d_q >= VALUE_BITS'(WHEEL_FIRST))
		else $error("wheel divisor below its first value");

	a_tiny_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && n_in <= VALUE_BITS'(1)) |=> (state_q == ST_FIN && !res_q))
		else $error("zero or one not rejected at once");

	a_start_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == ST_WAIT && !div_done))
		else $error("divider start not followed by a wait");

endmodule

`default_nettype wire

// ===== rtl/ptd_serial_div.sv =====
// Radix-2 restoring divider: one quotient bit per cycle through shift registers.
// Depends on ptd_pkg for the default width.
`default_nettype none

module ptd_serial_div
	import ptd_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] dividend,
	input  wire logic [VALUE_BITS-1:0] divisor,
	output logic                       done,
	output logic [VALUE_BITS-1:0]      quotient,
	output logic [VALUE_BITS-1:0]      remainder
);

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] num_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] den_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;
	logic                  qbit;

	assign trial = {rem_q, num_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = ~diff[VALUE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(VALUE_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[VALUE_BITS-2:0], qbit};
			rem_q <= qbit ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire
